FILE: src/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared types for the interval set range tracker: opcodes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

  localparam int unsigned StartW = 48;
  localparam int unsigned EndW   = 49;
  localparam int unsigned LenW   = 32;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_GAPS  = 2'd2,
    OP_BYTES = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_PLC,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;   // latch the incoming word
    logic rd;      // read entry at the walk index
    logic ev;      // evaluate the entry just read
    logic plc;     // write back the held entry after placing the new one
    logic fpush;   // push the tail gap of a gap listing
    logic finish;  // produce the final result, commit an insert
  } cmd_t;

  typedef struct packed {
    logic out_busy;   // result register still holds a word
    logic walk_done;  // no more entries to visit
    logic place_old;  // evaluation placed the new interval before this entry
    logic push_need;  // gap listing still has an uncovered tail
  } status_t;

endpackage

`default_nettype wire

FILE: src/interval_set_range_tracker_core.sv
// ----------------------------------------------------------------------------
// interval_set_range_tracker_core
// Sorted table of disjoint cached byte intervals with merge on insert,
// coverage query, gap listing and cached byte total.
// ----------------------------------------------------------------------------
// Walk: an item visits the stored entries one at a time, each with a memory
// read and then an evaluate; the entry that follows a freshly placed interval
// also takes a write-back step. After the walk the final result word is loaded
// into the result register; a gap listing with an uncovered tail adds a push.
// Throughput: one word at a time; the next word is taken only after the final
// result word is loaded. Each extra gap word of a listing waits until the
// previous one is taken, and the walk of the next item holds while the
// previous final word is not taken.
// Reset: interval count and control clear at once; storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_range_tracker_core #(
  parameter int unsigned MAX_INTERVALS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [1:0]                    op_i,
  input  wire [isrt_pkg::StartW-1:0]   start_req_i,
  input  wire [isrt_pkg::LenW-1:0]     length_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         is_cached_o,
  output logic                         has_gap_o,
  output logic [isrt_pkg::StartW-1:0]  gap_start_o,
  output logic [isrt_pkg::EndW-1:0]    gap_end_o,
  output logic [isrt_pkg::EndW-1:0]    cached_bytes_o,
  output logic                         table_full_o,
  output logic                         last_o
);

  isrt_pkg::cmd_t    cmd;
  isrt_pkg::status_t status;

  // sequence the walk
  isrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold the table and build each result word
  isrt_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .start_req_i    (start_req_i),
    .length_i       (length_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_cached_o    (is_cached_o),
    .has_gap_o      (has_gap_o),
    .gap_start_o    (gap_start_o),
    .gap_end_o      (gap_end_o),
    .cached_bytes_o (cached_bytes_o),
    .table_full_o   (table_full_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

FILE: src/isrt_ctrl.sv
// ----------------------------------------------------------------------------
// isrt_ctrl
// Sequencer: walks the interval table one entry at a time, a read and then
// an evaluate per entry, and hands commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  isrt_pkg::status_t      status_i,
  output isrt_pkg::cmd_t         cmd_o
);

  isrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != isrt_pkg::ST_IDLE);
    case (state_q)
      isrt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = isrt_pkg::ST_RD;
        end
      end
      isrt_pkg::ST_RD: begin
        if (status_i.walk_done) begin
          state_d = isrt_pkg::ST_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = isrt_pkg::ST_EV;
        end
      end
      isrt_pkg::ST_EV: begin
        // hold while a word waits at the output
        if (!status_i.out_busy) begin
          cmd_o.ev = 1'b1;
          state_d  = status_i.place_old ? isrt_pkg::ST_PLC : isrt_pkg::ST_RD;
        end
      end
      isrt_pkg::ST_PLC: begin
        cmd_o.plc = 1'b1;
        state_d   = isrt_pkg::ST_RD;
      end
      isrt_pkg::ST_FIN: begin
        if (!status_i.out_busy) begin
          if (status_i.push_need) begin
            cmd_o.fpush = 1'b1;
          end else begin
            state_d = isrt_pkg::ST_DONE;
          end
        end
      end
      isrt_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = isrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = isrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/isrt_dp.sv
// ----------------------------------------------------------------------------
// isrt_dp
// Datapath: two banks of interval storage, the walk registers and the
// result register. An insert rebuilds the table into the idle bank.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_dp #(
  parameter int unsigned MAX_INTERVALS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire [1:0]                          op_i,
  input  wire [isrt_pkg::StartW-1:0]         start_req_i,
  input  wire [isrt_pkg::LenW-1:0]           length_i,
  input  isrt_pkg::cmd_t                     cmd_i,
  output isrt_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               is_cached_o,
  output logic                               has_gap_o,
  output logic [isrt_pkg::StartW-1:0]        gap_start_o,
  output logic [isrt_pkg::EndW-1:0]          gap_end_o,
  output logic [isrt_pkg::EndW-1:0]          cached_bytes_o,
  output logic                               table_full_o,
  output logic                               last_o
);

  localparam int unsigned IW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW    = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned Depth = 2 ** (IW + 1);
  localparam int unsigned SW    = isrt_pkg::StartW;
  localparam int unsigned EW    = isrt_pkg::EndW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_INTERVALS);

  // storage, two banks addressed by {bank, index}
  logic [SW-1:0] mem_s [Depth];
  logic [EW-1:0] mem_e [Depth];
  logic [SW-1:0] rd_s_q;
  logic [EW-1:0] rd_e_q;

  // control registers
  logic          bank_q, bank_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic          skip_q, skip_d;
  logic          merged_q, merged_d;
  logic          placed_q, placed_d;
  logic          stop_q, stop_d;
  logic          hit_q, hit_d;
  logic          pv_q, pv_d;
  logic          ov_q, ov_d;

  // payload registers
  isrt_pkg::op_e op_q, op_d;
  logic [EW-1:0] s_q, s_d;     // start of insert, or gap cursor
  logic [EW-1:0] rs_q, rs_d;   // request start for coverage query
  logic [EW-1:0] e_q, e_d;
  logic [EW-1:0] tot_q, tot_d;
  logic [SW-1:0] ps_q, ps_d;
  logic [EW-1:0] pe_q, pe_d;
  logic          o_cached_q, o_cached_d;
  logic          o_gap_q, o_gap_d;
  logic [SW-1:0] o_gs_q, o_gs_d;
  logic [EW-1:0] o_ge_q, o_ge_d;
  logic [EW-1:0] o_bytes_q, o_bytes_d;
  logic          o_full_q, o_full_d;
  logic          o_last_q, o_last_d;

  // write port
  logic          we;
  logic [SW-1:0] wd_s;
  logic [EW-1:0] wd_e;

  logic [EW-1:0] a_ext;
  logic          keep_ent, merge_ent, place_ent, drop;

  assign a_ext     = {1'b0, rd_s_q};
  assign keep_ent  = rd_e_q < s_q;
  assign merge_ent = !keep_ent && (a_ext <= e_q);
  assign place_ent = !keep_ent && !merge_ent;
  assign drop      = !merged_q && (count_q >= MaxCnt);

  assign status_o.out_busy  = ov_q;
  assign status_o.walk_done = skip_q || stop_q || (idx_q >= count_q);
  assign status_o.place_old = (op_q == isrt_pkg::OP_MARK) && place_ent && !placed_q;
  assign status_o.push_need = (op_q == isrt_pkg::OP_GAPS) && !skip_q && (s_q < e_q);

  always_comb begin
    bank_d = bank_q;  count_d = count_q;  idx_d = idx_q;  n_d = n_q;
    skip_d = skip_q;  merged_d = merged_q;  placed_d = placed_q;
    stop_d = stop_q;  hit_d = hit_q;  pv_d = pv_q;
    op_d = op_q;  s_d = s_q;  rs_d = rs_q;  e_d = e_q;  tot_d = tot_q;
    ps_d = ps_q;  pe_d = pe_q;
    ov_d = ov_q && out_stall_i;
    o_cached_d = o_cached_q;  o_gap_d = o_gap_q;  o_gs_d = o_gs_q;
    o_ge_d = o_ge_q;  o_bytes_d = o_bytes_q;  o_full_d = o_full_q;
    o_last_d = o_last_q;
    we = 1'b0;  wd_s = rd_s_q;  wd_e = rd_e_q;

    if (cmd_i.start) begin
      op_d     = isrt_pkg::op_e'(op_i);
      s_d      = {1'b0, start_req_i};
      rs_d     = {1'b0, start_req_i};
      e_d      = {1'b0, start_req_i} + {{(EW-isrt_pkg::LenW){1'b0}}, length_i};
      skip_d   = (length_i == '0) && (op_i != isrt_pkg::OP_BYTES);
      hit_d    = (length_i == '0);
      idx_d    = '0;
      n_d      = '0;
      merged_d = 1'b0;
      placed_d = 1'b0;
      stop_d   = 1'b0;
      pv_d     = 1'b0;
      tot_d    = '0;
    end

    if (cmd_i.ev) begin
      idx_d = idx_q + CW'(1);
      case (op_q)
        isrt_pkg::OP_MARK: begin
          if (keep_ent) begin
            we  = 1'b1;
            n_d = n_q + CW'(1);
          end else if (merge_ent) begin
            merged_d = 1'b1;
            if (a_ext < s_q) s_d = a_ext;
            if (rd_e_q > e_q) e_d = rd_e_q;
          end else if (!placed_q) begin
            // new interval goes first, old entry follows next cycle
            we       = 1'b1;
            wd_s     = s_q[SW-1:0];
            wd_e     = e_q;
            n_d      = n_q + CW'(1);
            placed_d = 1'b1;
          end else begin
            we  = 1'b1;
            n_d = n_q + CW'(1);
          end
        end
        isrt_pkg::OP_QUERY: begin
          if (a_ext <= rs_q && rd_e_q >= e_q) hit_d = 1'b1;
        end
        isrt_pkg::OP_GAPS: begin
          if (rd_e_q <= s_q) begin
            // entry lies wholly behind the cursor
          end else if (a_ext >= e_q) begin
            stop_d = 1'b1;
          end else begin
            if (a_ext > s_q) begin
              if (pv_q) begin
                ov_d = 1'b1;  o_cached_d = 1'b0;  o_gap_d = 1'b1;
                o_gs_d = ps_q;  o_ge_d = pe_q;  o_bytes_d = '0;
                o_full_d = 1'b0;  o_last_d = 1'b0;
              end
              pv_d = 1'b1;
              ps_d = s_q[SW-1:0];
              pe_d = a_ext;
            end
            s_d = rd_e_q;
            if (rd_e_q >= e_q) stop_d = 1'b1;
          end
        end
        default: begin
          tot_d = tot_q + (rd_e_q - a_ext);
        end
      endcase
    end

    if (cmd_i.plc) begin
      we  = 1'b1;
      n_d = n_q + CW'(1);
    end

    if (cmd_i.fpush) begin
      if (pv_q) begin
        ov_d = 1'b1;  o_cached_d = 1'b0;  o_gap_d = 1'b1;
        o_gs_d = ps_q;  o_ge_d = pe_q;  o_bytes_d = '0;
        o_full_d = 1'b0;  o_last_d = 1'b0;
      end
      pv_d = 1'b1;
      ps_d = s_q[SW-1:0];
      pe_d = e_q;
      s_d  = e_q;
    end

    if (cmd_i.finish) begin
      ov_d = 1'b1;  o_cached_d = 1'b0;  o_gap_d = 1'b0;  o_gs_d = '0;
      o_ge_d = '0;  o_bytes_d = '0;  o_full_d = 1'b0;  o_last_d = 1'b1;
      case (op_q)
        isrt_pkg::OP_MARK: begin
          if (!skip_q) begin
            if (drop) begin
              o_full_d = 1'b1;
            end else begin
              if (!placed_q) begin
                we   = 1'b1;
                wd_s = s_q[SW-1:0];
                wd_e = e_q;
              end
              count_d = placed_q ? n_q : n_q + CW'(1);
              bank_d  = !bank_q;
            end
          end
        end
        isrt_pkg::OP_QUERY: o_cached_d = hit_q;
        isrt_pkg::OP_GAPS: begin
          if (pv_q) begin
            o_gap_d = 1'b1;
            o_gs_d  = ps_q;
            o_ge_d  = pe_q;
          end
        end
        default: o_bytes_d = tot_q;
      endcase
    end
  end

  // drop writes past the end of the bank; only a dropped insert gets there
  always_ff @(posedge clk_i) begin
    if (we && (n_q < MaxCnt)) begin
      mem_s[{!bank_q, n_q[IW-1:0]}] <= wd_s;
      mem_e[{!bank_q, n_q[IW-1:0]}] <= wd_e;
    end
    if (cmd_i.rd) begin
      rd_s_q <= mem_s[{bank_q, idx_q[IW-1:0]}];
      rd_e_q <= mem_e[{bank_q, idx_q[IW-1:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;  count_q <= '0;  idx_q <= '0;  n_q <= '0;
      skip_q <= 1'b0;  merged_q <= 1'b0;  placed_q <= 1'b0;
      stop_q <= 1'b0;  hit_q <= 1'b0;  pv_q <= 1'b0;  ov_q <= 1'b0;
    end else begin
      bank_q <= bank_d;  count_q <= count_d;  idx_q <= idx_d;  n_q <= n_d;
      skip_q <= skip_d;  merged_q <= merged_d;  placed_q <= placed_d;
      stop_q <= stop_d;  hit_q <= hit_d;  pv_q <= pv_d;  ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  s_q <= s_d;  rs_q <= rs_d;  e_q <= e_d;  tot_q <= tot_d;
    ps_q <= ps_d;  pe_q <= pe_d;
    o_cached_q <= o_cached_d;  o_gap_q <= o_gap_d;  o_gs_q <= o_gs_d;
    o_ge_q <= o_ge_d;  o_bytes_q <= o_bytes_d;  o_full_q <= o_full_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o    = ov_q;
  assign is_cached_o    = o_cached_q;
  assign has_gap_o      = o_gap_q;
  assign gap_start_o    = o_gs_q;
  assign gap_end_o      = o_ge_q;
  assign cached_bytes_o = o_bytes_q;
  assign table_full_o   = o_full_q;
  assign last_o         = o_last_q;

endmodule

`default_nettype wire
